// ----- sv/dru_pkg.sv -----
package dru_pkg;

    localparam int DATA_W        = 16;
    localparam int NUM_IN        = 4;
    localparam int FRAC_BITS_DEF = 12;
    localparam int RATE_W        = 13;
    localparam int RATE_FRAC     = 12;
    localparam logic [RATE_W-1:0] RATE_RESET = 13'd2048;

    // x * w
    localparam int PROD_W = 2 * DATA_W;
    // rate (as signed) * error
    localparam int RE_W   = RATE_W + 1 + DATA_W;
    // rate * error * x
    localparam int SP_W   = RE_W + DATA_W;
    localparam int SAT_W  = 48;

    localparam logic signed [SAT_W-1:0] Q_MAX = 48'sd32767;
    localparam logic signed [SAT_W-1:0] Q_MIN = -48'sd32768;

    typedef logic signed [DATA_W-1:0] q_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_ERR,
        ST_RATE,
        ST_SCALE,
        ST_UPD
    } state_t;

    typedef struct packed {
        logic mul;
        logic sum;
        logic err;
        logic rate;
        logic scale;
        logic upd;
    } ctl_t;

    function automatic q_t sat_q(input logic signed [SAT_W-1:0] v);
        q_t r;
        if (v > Q_MAX)
        begin
            r = 16'sh7fff;
        end
        else if (v < Q_MIN)
        begin
            r = 16'sh8000;
        end
        else
        begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

// ----- sv/dru_in_if.sv -----
interface dru_in_if;
    logic          valid;
    logic          ready;
    dru_pkg::q_t   x_0;
    dru_pkg::q_t   x_1;
    dru_pkg::q_t   x_2;
    dru_pkg::q_t   x_3;
    dru_pkg::q_t   target;

    modport source (output valid, x_0, x_1, x_2, x_3, target, input ready);
    modport sink   (input valid, x_0, x_1, x_2, x_3, target, output ready);
endinterface

// ----- sv/dru_out_if.sv -----
interface dru_out_if;
    logic          valid;
    logic          ready;
    dru_pkg::q_t   net_input;
    dru_pkg::q_t   error;
    dru_pkg::q_t   delta_0;
    dru_pkg::q_t   delta_1;
    dru_pkg::q_t   delta_2;
    dru_pkg::q_t   delta_3;
    dru_pkg::q_t   weight_0;
    dru_pkg::q_t   weight_1;
    dru_pkg::q_t   weight_2;
    dru_pkg::q_t   weight_3;

    modport source (output valid, net_input, error, delta_0, delta_1, delta_2, delta_3,
                    weight_0, weight_1, weight_2, weight_3, input ready);
    modport sink   (input valid, net_input, error, delta_0, delta_1, delta_2, delta_3,
                    weight_0, weight_1, weight_2, weight_3, output ready);
endinterface

// ----- sv/dru_cfg_if.sv -----
interface dru_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [dru_pkg::RATE_W-1:0]    learning_rate;

    modport source (output valid, learning_rate, input ready);
    modport sink   (input valid, learning_rate, output ready);
endinterface

// ----- sv/dru_lane.sv -----
module dru_lane #(
    parameter int FRAC_BITS = dru_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  dru_pkg::ctl_t                       ctl,
    input  dru_pkg::q_t                         x,
    input  logic signed [dru_pkg::RE_W-1:0]     rate_err,
    output logic signed [dru_pkg::PROD_W-1:0]   prod,
    output dru_pkg::q_t                         delta,
    output dru_pkg::q_t                         weight
);

    localparam int SH = dru_pkg::RATE_FRAC + FRAC_BITS;
    localparam int TW = dru_pkg::SP_W + 1;
    localparam logic signed [TW-1:0] HALF = {{(TW-SH){1'b0}}, 1'b1, {(SH-1){1'b0}}};

    logic signed [dru_pkg::PROD_W-1:0] prod_reg;
    logic signed [dru_pkg::SP_W-1:0]   sp_reg;
    dru_pkg::q_t                       w_reg;
    dru_pkg::q_t                       w_next;
    dru_pkg::q_t                       delta_reg;
    dru_pkg::q_t                       delta_next;
    logic signed [TW-1:0]              rnd;
    logic signed [TW-1:0]              shifted;
    logic signed [dru_pkg::DATA_W:0]   wsum;

    always_comb
    begin
        rnd        = TW'(sp_reg) + HALF;
        shifted    = rnd >>> SH;
        delta_next = dru_pkg::sat_q(dru_pkg::SAT_W'(shifted));
        wsum       = (dru_pkg::DATA_W+1)'(w_reg) + (dru_pkg::DATA_W+1)'(delta_next);
        w_next     = dru_pkg::sat_q(dru_pkg::SAT_W'(wsum));
    end

    always_ff @(posedge clk)
    begin
        if (ctl.mul)
        begin
            prod_reg <= x * w_reg;
        end
        if (ctl.scale)
        begin
            sp_reg <= rate_err * x;
        end
        if (ctl.upd)
        begin
            delta_reg <= delta_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg <= '0;
        end
        else if (ctl.upd)
        begin
            w_reg <= w_next;
        end
    end

    assign prod   = prod_reg;
    assign delta  = delta_reg;
    assign weight = w_reg;

endmodule

// ----- sv/dru_merge.sv -----
module dru_merge #(
    parameter int FRAC_BITS = dru_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  dru_pkg::ctl_t                       ctl,
    input  logic signed [dru_pkg::PROD_W-1:0]   prods [dru_pkg::NUM_IN],
    input  dru_pkg::q_t                         target,
    input  logic [dru_pkg::RATE_W-1:0]          rate,
    output dru_pkg::q_t                         net,
    output dru_pkg::q_t                         err,
    output logic signed [dru_pkg::RE_W-1:0]     rate_err
);

    localparam int ACC_W = dru_pkg::PROD_W + $clog2(dru_pkg::NUM_IN) + 1;
    localparam logic signed [ACC_W-1:0] HALF =
        {{(ACC_W-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};

    logic signed [ACC_W-1:0]           acc_reg;
    logic signed [ACC_W-1:0]           acc_next;
    logic signed [ACC_W-1:0]           shifted;
    dru_pkg::q_t                       net_reg;
    dru_pkg::q_t                       net_next;
    dru_pkg::q_t                       err_reg;
    dru_pkg::q_t                       err_next;
    logic signed [dru_pkg::DATA_W:0]   diff;
    logic signed [dru_pkg::RE_W-1:0]   re_reg;
    logic signed [dru_pkg::RATE_W:0]   rate_s;

    always_comb
    begin
        acc_next = HALF;
        for (int i = 0; i < dru_pkg::NUM_IN; i++)
        begin
            acc_next = acc_next + ACC_W'(prods[i]);
        end
        shifted  = acc_reg >>> FRAC_BITS;
        net_next = dru_pkg::sat_q(dru_pkg::SAT_W'(shifted));
        diff     = (dru_pkg::DATA_W+1)'(target) - (dru_pkg::DATA_W+1)'(net_next);
        err_next = dru_pkg::sat_q(dru_pkg::SAT_W'(diff));
        rate_s   = $signed({1'b0, rate});
    end

    always_ff @(posedge clk)
    begin
        if (ctl.sum)
        begin
            acc_reg <= acc_next;
        end
        if (ctl.err)
        begin
            net_reg <= net_next;
            err_reg <= err_next;
        end
        if (ctl.rate)
        begin
            re_reg <= rate_s * err_reg;
        end
    end

    assign net      = net_reg;
    assign err      = err_reg;
    assign rate_err = re_reg;

endmodule

// ----- sv/delta_rule_weight_update.sv -----
// Delta-rule (LMS) trainer for a four-input linear unit, signed Q4.12 data.
// sample: one beat carries x_0..x_3 and target. result: one beat per sample
// with net input, error, the four weight changes and the updated weights.
// cfg: learning rate (unsigned Q1.12), always ready; write only while idle.
// Each sample runs through six steps: lane products x*w, adder tree, round
// and error, rate*error, lane scaling by x, then saturate and weight write.
// The result is registered at the weight-write step and then shown valid. The next
// sample is taken in the weight-write cycle: the weight feedback through the
// product/sum/error chain lets a sample enter only once the last one is there.
// The finished result sits in an output register; while the receiver stalls
// the next sample is accepted and worked on up to the scaling step, then
// holds until the previous result beat has gone.
// Reset clears the weights to zero, sets the rate to 0.5 and drops any
// pending result.
module delta_rule_weight_update #(
    parameter int FRAC_BITS = dru_pkg::FRAC_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    dru_in_if.sink        sample,
    dru_out_if.source     result,
    dru_cfg_if.sink       cfg
);

    dru_pkg::state_t                   state_reg;
    dru_pkg::state_t                   state_next;
    dru_pkg::ctl_t                     ctl;
    logic                              accept;
    logic                              out_valid_reg;
    logic [dru_pkg::RATE_W-1:0]        rate_reg;
    dru_pkg::q_t                       x_reg [dru_pkg::NUM_IN];
    dru_pkg::q_t                       target_reg;
    dru_pkg::q_t                       onet_reg;
    dru_pkg::q_t                       oerr_reg;
    logic signed [dru_pkg::PROD_W-1:0] prods [dru_pkg::NUM_IN];
    dru_pkg::q_t                       deltas [dru_pkg::NUM_IN];
    dru_pkg::q_t                       weights [dru_pkg::NUM_IN];
    dru_pkg::q_t                       net;
    dru_pkg::q_t                       err;
    logic signed [dru_pkg::RE_W-1:0]   rate_err;

    assign sample.ready = (state_reg == dru_pkg::ST_IDLE) || (state_reg == dru_pkg::ST_UPD);
    assign accept       = sample.valid && sample.ready;
    assign cfg.ready    = 1'b1;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        case (state_reg)
            dru_pkg::ST_IDLE:
            begin
                if (sample.valid)
                begin
                    state_next = dru_pkg::ST_MUL;
                end
            end
            dru_pkg::ST_MUL:
            begin
                ctl.mul    = 1'b1;
                state_next = dru_pkg::ST_SUM;
            end
            dru_pkg::ST_SUM:
            begin
                ctl.sum    = 1'b1;
                state_next = dru_pkg::ST_ERR;
            end
            dru_pkg::ST_ERR:
            begin
                ctl.err    = 1'b1;
                state_next = dru_pkg::ST_RATE;
            end
            dru_pkg::ST_RATE:
            begin
                ctl.rate   = 1'b1;
                state_next = dru_pkg::ST_SCALE;
            end
            dru_pkg::ST_SCALE:
            begin
                ctl.scale = 1'b1;
                // lanes' delta/weight registers double as the result register
                if (!out_valid_reg || result.ready)
                begin
                    state_next = dru_pkg::ST_UPD;
                end
            end
            dru_pkg::ST_UPD:
            begin
                ctl.upd    = 1'b1;
                state_next = sample.valid ? dru_pkg::ST_MUL : dru_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = dru_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dru_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            rate_reg      <= dru_pkg::RATE_RESET;
        end
        else
        begin
            state_reg <= state_next;
            if (ctl.upd)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg.valid)
            begin
                rate_reg <= cfg.learning_rate;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg[0]   <= sample.x_0;
            x_reg[1]   <= sample.x_1;
            x_reg[2]   <= sample.x_2;
            x_reg[3]   <= sample.x_3;
            target_reg <= sample.target;
        end
        if (ctl.upd)
        begin
            onet_reg <= net;
            oerr_reg <= err;
        end
    end

    for (genvar i = 0; i < dru_pkg::NUM_IN; i++)
    begin : g_lane
        dru_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl),
            .x        (x_reg[i]),
            .rate_err (rate_err),
            .prod     (prods[i]),
            .delta    (deltas[i]),
            .weight   (weights[i])
        );
    end

    dru_merge #(
        .FRAC_BITS (FRAC_BITS)
    ) u_merge (
        .clk      (clk),
        .ctl      (ctl),
        .prods    (prods),
        .target   (target_reg),
        .rate     (rate_reg),
        .net      (net),
        .err      (err),
        .rate_err (rate_err)
    );

    assign result.valid     = out_valid_reg;
    assign result.net_input = onet_reg;
    assign result.error     = oerr_reg;
    assign result.delta_0   = deltas[0];
    assign result.delta_1   = deltas[1];
    assign result.delta_2   = deltas[2];
    assign result.delta_3   = deltas[3];
    assign result.weight_0  = weights[0];
    assign result.weight_1  = weights[1];
    assign result.weight_2  = weights[2];
    assign result.weight_3  = weights[3];

    // weight write must never overrun a result still waiting
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == dru_pkg::ST_UPD |-> !out_valid_reg || result.ready)
        else $error("weight write while result pending");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == dru_pkg::ST_MUL)
        else $error("accepted sample not started");

    a_upd_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == dru_pkg::ST_UPD |=> out_valid_reg)
        else $error("weight write without result");

    a_scale_holds: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == dru_pkg::ST_SCALE && out_valid_reg && !result.ready
        |=> state_reg == dru_pkg::ST_SCALE)
        else $error("scale step left while output stalled");

endmodule
